@@ src/mdp_u52_pkg.sv @@
package mdp_u52_pkg;

    // Fixed widths of the ports.
    localparam int ELEM_W    = 52;
    localparam int MOD_W     = 53;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 4;

    // Running sum width and the width of the counter of shift-subtract steps that reduce it.
    localparam int SUM_W     = 128;
    localparam int RED_CNT_W = $clog2(SUM_W);

    // Multiply sequencing: four partial products, the last one added in a final step.
    localparam int STEP_W    = 3;
    localparam logic [STEP_W-1:0] MAC_LAST_STEP = 3'd4;

    // Register map.
    localparam logic [APB_AW-1:0] ADDR_MODULUS = 4'h0;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_LEN     = 16777216;
    localparam int DEF_VALUE_WIDTH = 52;

    localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1) << 52;

    typedef struct packed {
        logic        load;       // capture operands, advance the term count
        logic        mul_en;     // register one partial product
        logic [1:0]  mul_sel;    // which operand halves to multiply
        logic        add_en;     // add the registered partial product to the sum
        logic [1:0]  add_sel;    // weight of the registered partial product
        logic        red_start;  // latch modulus and flag, clear the count
        logic        red_step;   // one shift-subtract step of the reduction
        logic        out_load;   // move the residue into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

@@ src/mdp_u52_dpath.sv @@
module mdp_u52_dpath
    import mdp_u52_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int MAX_LEN     = DEF_MAX_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic [ELEM_W-1:0] element_a,
    input  logic [ELEM_W-1:0] element_b,
    input  logic              last,
    input  logic [MOD_W-1:0]  modulus,
    output logic [ELEM_W-1:0] dot_residue,
    output logic              too_long
);

    localparam int HALF_W = (VALUE_WIDTH + 1) / 2;
    localparam int HIGH_W = VALUE_WIDTH - HALF_W;
    localparam int PROD_W = 2 * HALF_W;
    localparam int VW1    = VALUE_WIDTH + 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 2);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
    localparam logic [MOD_W-1:0] MOD_CAP = MOD_W'(1) << VALUE_WIDTH;

    logic [VALUE_WIDTH-1:0] a_reg, b_reg;
    logic                   last_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [VW1-1:0]         mod_reg;
    logic                   mod_zero_reg;
    logic                   flag_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [ELEM_W-1:0]      residue_reg;
    logic                   too_long_reg;

    logic [HALF_W-1:0]      op_a, op_b;
    logic [SUM_W-1:0]       addend;
    logic [VW1-1:0]         trial;
    logic [VW1-1:0]         diff;
    logic [VW1-1:0]         mod_eff;

    always_comb begin
        op_a = cmd.mul_sel[1] ? HALF_W'(a_reg[VALUE_WIDTH-1 -: HIGH_W]) : a_reg[HALF_W-1:0];
        op_b = cmd.mul_sel[0] ? HALF_W'(b_reg[VALUE_WIDTH-1 -: HIGH_W]) : b_reg[HALF_W-1:0];
    end

    // Cross terms carry weight 2^HALF_W, the high-high term 2^(2*HALF_W).
    always_comb begin
        unique case (cmd.add_sel)
            2'd0:    addend = SUM_W'(prod_reg);
            2'd3:    addend = SUM_W'(prod_reg) << (2 * HALF_W);
            default: addend = SUM_W'(prod_reg) << HALF_W;
        endcase
    end

    always_comb begin
        trial = {rem_reg, sum_reg[SUM_W-1]};
        diff  = trial - mod_reg;
        if (modulus > MOD_CAP) begin
            mod_eff = MOD_CAP[VW1-1:0];
        end else begin
            mod_eff = modulus[VW1-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg    <= element_a[VALUE_WIDTH-1:0];
            b_reg    <= element_b[VALUE_WIDTH-1:0];
            last_reg <= last;
        end
        if (cmd.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.red_start) begin
            mod_reg      <= mod_eff;
            mod_zero_reg <= (modulus == '0);
            flag_reg     <= (count_reg > CNT_MAX);
        end
        if (cmd.red_start) begin
            rem_reg <= '0;
        end else if (cmd.red_step) begin
            if (trial >= mod_reg) begin
                rem_reg <= diff[VALUE_WIDTH-1:0];
            end else begin
                rem_reg <= trial[VALUE_WIDTH-1:0];
            end
        end
        if (cmd.out_load) begin
            residue_reg  <= mod_zero_reg ? '0 : ELEM_W'(rem_reg);
            too_long_reg <= flag_reg;
        end
    end

    // The reduction shifts the sum out from the top, which leaves it cleared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.add_en) begin
                sum_reg <= sum_reg + addend;
            end else if (cmd.red_step) begin
                sum_reg <= sum_reg << 1;
            end
            if (cmd.red_start) begin
                count_reg <= '0;
            end else if (cmd.load && count_reg <= CNT_MAX) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign status.last = last_reg;
    assign dot_residue = residue_reg;
    assign too_long    = too_long_reg;

endmodule

@@ src/mdp_u52_ctrl.sv @@
module mdp_u52_ctrl
    import mdp_u52_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [RED_CNT_W-1:0] red_cnt_reg, red_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        red_cnt_next   = red_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_ready        = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                // Multiply of one partial product overlaps the add of the one before.
                cmd.mul_en  = (step_reg != MAC_LAST_STEP);
                cmd.mul_sel = step_reg[1:0];
                cmd.add_en  = (step_reg != '0);
                cmd.add_sel = 2'(step_reg - 1'b1);
                step_next   = step_reg + 1'b1;
                if (step_reg == MAC_LAST_STEP) begin
                    if (status.last) begin
                        cmd.red_start = 1'b1;
                        red_cnt_next  = '0;
                        state_next    = ST_RED;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RED: begin
                cmd.red_step = 1'b1;
                red_cnt_next = red_cnt_reg + 1'b1;
                if (red_cnt_reg == '1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            red_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            red_cnt_reg   <= red_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    // A waiting result must never be overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register loaded while a transaction was pending");

    // The reduction always starts from step zero, so it runs a full pass before the result is loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.red_start |=> (state_reg == ST_RED && red_cnt_reg == '0))
        else $error("reduction did not start from step zero");

    // Operands are never replaced while the sum is being updated or reduced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!cmd.add_en && !cmd.red_step && !cmd.out_load))
        else $error("new transaction accepted during arithmetic");

    // A result is presented in the cycle after its load.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");

endmodule

@@ src/modular_dot_product_u52.sv @@
// Channel   Ports                                              Direction
// s_        s_valid/s_ready, s_element_a, s_element_b, s_last  in: one vector term
// m_        m_valid/m_ready, m_dot_residue, m_too_long          out: one per dot product
// APB       psel/penable/pwrite/paddr/pwdata/prdata/pready     modulus at address 0
//
// A term is taken in idle and then runs the multiply steps: four 26x26 partial products
// through one multiplier, one add per partial product into the 128-bit sum.
// A term marked last adds a bit-serial reduction of all 128 sum bits and a load.
// Reset (aresetn, synchronous) clears the sum, the count, the modulus to 2^52.
// The next term is taken while a result waits; a stalled result holds the block
// only when the following result is ready to be loaded.
module modular_dot_product_u52
    import mdp_u52_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int MAX_LEN     = DEF_MAX_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ELEM_W-1:0] s_element_a,
    input  logic [ELEM_W-1:0] s_element_b,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ELEM_W-1:0] m_dot_residue,
    output logic              m_too_long,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [MOD_W-1:0] modulus_reg;
    logic             mod_sel;

    // Registers are 8 bytes apart; the byte offset bits are ignored.
    assign mod_sel = (paddr[APB_AW-1] == ADDR_MODULUS[APB_AW-1]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (psel && penable && pwrite && pready && mod_sel) begin
            modulus_reg <= pwdata[MOD_W-1:0];
        end
    end

    assign prdata = mod_sel ? APB_DW'(modulus_reg) : '0;

    mdp_u52_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mdp_u52_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_LEN     (MAX_LEN)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .element_a   (s_element_a),
        .element_b   (s_element_b),
        .last        (s_last),
        .modulus     (modulus_reg),
        .dot_residue (m_dot_residue),
        .too_long    (m_too_long)
    );

endmodule
